/* design/console_bus_memory_map_unit_defines.svh */
// Assertion macros shared by the console bus memory map unit.
`ifndef CONSOLE_BUS_MEMORY_MAP_UNIT_DEFINES_SVH
`define CONSOLE_BUS_MEMORY_MAP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define CBMM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked at every rising clock edge out of reset.
`define CBMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CBMM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CBMM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/cbmm_pkg.sv */
// Types and constants of the console bus memory map unit.
`timescale 1ns / 1ps
`default_nettype none
package cbmm_pkg;

	// Address width of each internal 2 KB RAM.
	localparam int RAM_AW = 11;

	// Access kinds.
	localparam logic [1:0] FUNC_CPU_RD = 2'd0;
	localparam logic [1:0] FUNC_CPU_WR = 2'd1;
	localparam logic [1:0] FUNC_PPU_RD = 2'd2;
	localparam logic [1:0] FUNC_PPU_WR = 2'd3;

	// Target codes.
	localparam logic [3:0] TGT_NONE   = 4'd0;
	localparam logic [3:0] TGT_WRAM   = 4'd1;
	localparam logic [3:0] TGT_NTRAM  = 4'd2;
	localparam logic [3:0] TGT_PPUREG = 4'd3;
	localparam logic [3:0] TGT_APU    = 4'd4;
	localparam logic [3:0] TGT_PAD1   = 4'd5;
	localparam logic [3:0] TGT_PAD2   = 4'd6;
	localparam logic [3:0] TGT_PRG    = 4'd7;
	localparam logic [3:0] TGT_CHR    = 4'd8;
	localparam logic [3:0] TGT_PAL    = 4'd9;

	// One bus access.
	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] bus_address;
		logic [7:0]  write_data;
	} req_t;

	// One decoded result.
	typedef struct packed {
		logic [3:0]  target;
		logic [15:0] target_address;
		logic [7:0]  forward_data;
		logic        forward_write;
		logic [7:0]  read_data;
	} rsp_t;

	// Decoder output toward the RAM control and the result stage.
	typedef struct packed {
		logic [3:0]        target;
		logic [15:0]       target_address;
		logic              wr;
		logic              fwd;
		logic              wram_hit;
		logic              nt_hit;
		logic [RAM_AW-1:0] ram_index;
	} dec_t;

endpackage
`default_nettype wire

/* design/cbmm_ram.sv */
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cbmm_ram #(
	parameter int ADDR_W = 11,
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	// One access per cycle: write, or read into the output register.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* design/cbmm_decode.sv */
// Address decoder for the CPU and PPU memory maps with nametable mirroring.
`timescale 1ns / 1ps
`default_nettype none
module cbmm_decode (
	input  wire cbmm_pkg::req_t req,
	input  wire logic           mirroring_mode,
	output cbmm_pkg::dec_t      dec
);

	logic [15:0] addr;
	logic [13:0] ppu_a;
	logic        nt_bank;

	assign addr  = req.bus_address;
	assign ppu_a = req.bus_address[13:0];
	// Horizontal mode splits on the upper half, vertical on odd quadrants.
	assign nt_bank = mirroring_mode ? ppu_a[10] : ppu_a[11];

	always_comb begin
		dec           = '0;
		dec.wr        = req.func[0];
		dec.ram_index = {nt_bank, ppu_a[9:0]};
		if (!req.func[1]) begin
			// CPU map.
			dec.ram_index = addr[10:0];
			if (addr <= 16'h1FFF) begin
				dec.target         = cbmm_pkg::TGT_WRAM;
				dec.target_address = {5'd0, addr[10:0]};
				dec.wram_hit       = 1'b1;
			end else if (addr <= 16'h3FFF) begin
				dec.target         = cbmm_pkg::TGT_PPUREG;
				dec.target_address = 16'h2000 | {13'd0, addr[2:0]};
			end else if (addr <= 16'h4013 || addr == 16'h4015) begin
				dec.target         = cbmm_pkg::TGT_APU;
				dec.target_address = addr;
			end else if (addr == 16'h4014) begin
				dec.target         = cbmm_pkg::TGT_PPUREG;
				dec.target_address = addr;
			end else if (addr == 16'h4016) begin
				dec.target         = cbmm_pkg::TGT_PAD1;
				dec.target_address = addr;
			end else if (addr == 16'h4017) begin
				dec.target         = req.func[0] ? cbmm_pkg::TGT_APU : cbmm_pkg::TGT_PAD2;
				dec.target_address = addr;
			end else if (addr >= 16'h6000) begin
				dec.target         = cbmm_pkg::TGT_PRG;
				dec.target_address = addr;
			end
		end else begin
			// PPU map on the 14-bit folded address.
			if (ppu_a <= 14'h1FFF) begin
				dec.target         = cbmm_pkg::TGT_CHR;
				dec.target_address = {2'd0, ppu_a};
			end else if (ppu_a <= 14'h3EFF) begin
				dec.target         = cbmm_pkg::TGT_NTRAM;
				dec.target_address = {5'd0, nt_bank, ppu_a[9:0]};
				dec.nt_hit         = 1'b1;
			end else begin
				dec.target         = cbmm_pkg::TGT_PAL;
				dec.target_address = 16'h3F00 | {11'd0, ppu_a[4:0]};
			end
		end
		// External writes carry their data out.
		dec.fwd = dec.wr && !dec.wram_hit && !dec.nt_hit &&
			(dec.target != cbmm_pkg::TGT_NONE);
	end

endmodule
`default_nettype wire

/* design/console_bus_memory_map_unit.sv */
// Top level of the console bus memory map unit.
//
//  Channel   Signals                 Transfer when
//  command   start, busy, cmd        start high and busy low at a rising edge
//  result    done, result            done high; one cycle, cannot be held off
//  config    cfg_we, cfg_wdata       cfg_we high at a rising edge
//
// A command is decoded and its RAM access issued at the edge that accepts it;
// the result appears with done in the following cycle. While busy is low, a
// new command may follow in every cycle: a write lands at its own accept edge,
// before any later read. After reset the unit zeroes both 2048-entry RAMs, one
// entry of each per cycle, with busy high. Configuration is taken then too.
`timescale 1ns / 1ps
`default_nettype none
`include "console_bus_memory_map_unit_defines.svh"
module console_bus_memory_map_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire cbmm_pkg::req_t cmd,
	output logic                done,
	output cbmm_pkg::rsp_t      result,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata
);

	localparam int AW = cbmm_pkg::RAM_AW;

	logic                 mirror_q;
	logic                 clearing_q;
	logic [AW-1:0]        clr_idx_q;
	logic                 accept;
	cbmm_pkg::dec_t       dec;

	logic                 wram_en, nt_en, ram_we;
	logic [AW-1:0]        ram_addr;
	logic [7:0]           ram_wdata;
	logic [7:0]           wram_rdata, nt_rdata;

	logic                 done_s1;
	logic [3:0]           target_s1;
	logic [15:0]          taddr_s1;
	logic [7:0]           fdata_s1;
	logic                 fwrite_s1;
	logic                 rd_wram_s1, rd_nt_s1;

	// Mirroring mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 1'b0;
		end else if (cfg_we) begin
			mirror_q <= cfg_wdata;
		end
	end

	// Clearing sweep after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (&clr_idx_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign busy   = clearing_q;
	assign accept = start && !clearing_q;

	cbmm_decode u_decode (
		.req            (cmd),
		.mirroring_mode (mirror_q),
		.dec            (dec)
	);

	// RAM port control: the sweep owns both RAMs until it finishes.
	assign wram_en   = clearing_q || (accept && dec.wram_hit);
	assign nt_en     = clearing_q || (accept && dec.nt_hit);
	assign ram_we    = clearing_q || dec.wr;
	assign ram_addr  = clearing_q ? clr_idx_q : dec.ram_index;
	assign ram_wdata = clearing_q ? 8'd0 : cmd.write_data;

	cbmm_ram #(.ADDR_W(AW), .DATA_W(8)) u_work_ram (
		.clk   (clk),
		.en    (wram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (wram_rdata)
	);

	cbmm_ram #(.ADDR_W(AW), .DATA_W(8)) u_nametable_ram (
		.clk   (clk),
		.en    (nt_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (nt_rdata)
	);

	// Result stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	// Result stage payload, aligned with the RAM read data.
	always_ff @(posedge clk) begin
		if (accept) begin
			target_s1  <= dec.target;
			taddr_s1   <= dec.target_address;
			fdata_s1   <= dec.fwd ? cmd.write_data : 8'd0;
			fwrite_s1  <= dec.fwd;
			rd_wram_s1 <= dec.wram_hit && !dec.wr;
			rd_nt_s1   <= dec.nt_hit && !dec.wr;
		end
	end

	assign done                  = done_s1;
	assign result.target         = target_s1;
	assign result.target_address = taddr_s1;
	assign result.forward_data   = fdata_s1;
	assign result.forward_write  = fwrite_s1;
	assign result.read_data      = rd_wram_s1 ? wram_rdata :
		(rd_nt_s1 ? nt_rdata : 8'd0);

	// Every accepted transfer yields exactly one result on the next cycle.
	`CBMM_ASSERT_NEXT(a_accept_done, clk, arst_n, start && !busy, done)
	// No result follows from a clock edge at which the sweep held the unit busy.
	`CBMM_ASSERT_NEXT(a_busy_no_done, clk, arst_n, busy, !done)
	// Forwarded writes never go to the internal RAMs or to an open range.
	`CBMM_ASSERT_NOW(a_fwd_external, clk, arst_n, done && result.forward_write, result.target != cbmm_pkg::TGT_WRAM && result.target != cbmm_pkg::TGT_NTRAM && result.target != cbmm_pkg::TGT_NONE)
	// Nonzero read data only comes from an internal RAM.
	`CBMM_ASSERT_NOW(a_rdata_internal, clk, arst_n, done && result.read_data != 8'd0, result.target == cbmm_pkg::TGT_WRAM || result.target == cbmm_pkg::TGT_NTRAM)

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the console bus memory map unit.
`timescale 1ns / 1ps
module tb_top;

	// CPU and PPU address landmarks.
	localparam logic [15:0] CPU_WRAM_END   = 16'h1FFF;
	localparam logic [15:0] CPU_PPUREG_END = 16'h3FFF;
	localparam logic [15:0] CPU_APU_END    = 16'h4013;
	localparam logic [15:0] CPU_OAM_DMA    = 16'h4014;
	localparam logic [15:0] CPU_APU_STATUS = 16'h4015;
	localparam logic [15:0] CPU_PAD1       = 16'h4016;
	localparam logic [15:0] CPU_PAD2       = 16'h4017;
	localparam logic [15:0] CPU_PRG_START  = 16'h6000;
	localparam logic [13:0] PPU_CHR_END    = 14'h1FFF;
	localparam logic [13:0] PPU_NT_END     = 14'h3EFF;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	cbmm_pkg::req_t   cmd = '0;
	logic             done;
	cbmm_pkg::rsp_t   result;
	logic             cfg_we = 1'b0;
	logic             cfg_wdata = 1'b0;

	// Shadow copies of the two internal RAMs and the mirroring register.
	logic [7:0] wram_image [0:2047];
	logic [7:0] ntram_image [0:2047];
	logic       vertical_mirroring = 1'b0;

	cbmm_pkg::rsp_t expected_decode_q [$];
	int             fail_count = 0;

	console_bus_memory_map_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// 100 MHz clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog for a hung block.
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// Decode one access and update the shadow RAMs the way the block should.
	function automatic cbmm_pkg::rsp_t decode_access(cbmm_pkg::req_t r);
		cbmm_pkg::rsp_t o;
		logic           wr;
		logic           internal_hit;
		logic [13:0]    pa;
		logic [10:0]    idx;
		logic           bank;
		o = '0;
		wr = r.func[0];
		internal_hit = 1'b0;
		if (!r.func[1]) begin
			if (r.bus_address <= CPU_WRAM_END) begin
				idx = r.bus_address[10:0];
				o.target = cbmm_pkg::TGT_WRAM;
				o.target_address = {5'd0, idx};
				internal_hit = 1'b1;
				if (wr)
					wram_image[idx] = r.write_data;
				else
					o.read_data = wram_image[idx];
			end else if (r.bus_address <= CPU_PPUREG_END) begin
				o.target = cbmm_pkg::TGT_PPUREG;
				o.target_address = 16'h2000 | {13'd0, r.bus_address[2:0]};
			end else if (r.bus_address <= CPU_APU_END || r.bus_address == CPU_APU_STATUS) begin
				o.target = cbmm_pkg::TGT_APU;
				o.target_address = r.bus_address;
			end else if (r.bus_address == CPU_OAM_DMA) begin
				o.target = cbmm_pkg::TGT_PPUREG;
				o.target_address = r.bus_address;
			end else if (r.bus_address == CPU_PAD1) begin
				o.target = cbmm_pkg::TGT_PAD1;
				o.target_address = r.bus_address;
			end else if (r.bus_address == CPU_PAD2) begin
				// The frame counter shares this address on writes.
				o.target = wr ? cbmm_pkg::TGT_APU : cbmm_pkg::TGT_PAD2;
				o.target_address = r.bus_address;
			end else if (r.bus_address >= CPU_PRG_START) begin
				o.target = cbmm_pkg::TGT_PRG;
				o.target_address = r.bus_address;
			end
		end else begin
			pa = r.bus_address[13:0];
			if (pa <= PPU_CHR_END) begin
				o.target = cbmm_pkg::TGT_CHR;
				o.target_address = {2'b00, pa};
			end else if (pa <= PPU_NT_END) begin
				// Horizontal selects the bank by the 2 KB half, vertical by the 1 KB quadrant.
				bank = vertical_mirroring ? pa[10] : pa[11];
				idx = {bank, pa[9:0]};
				o.target = cbmm_pkg::TGT_NTRAM;
				o.target_address = {5'd0, idx};
				internal_hit = 1'b1;
				if (wr)
					ntram_image[idx] = r.write_data;
				else
					o.read_data = ntram_image[idx];
			end else begin
				o.target = cbmm_pkg::TGT_PAL;
				o.target_address = 16'h3F00 | {11'd0, pa[4:0]};
			end
		end
		if (wr && !internal_hit && o.target != cbmm_pkg::TGT_NONE) begin
			o.forward_write = 1'b1;
			o.forward_data = r.write_data;
		end
		return o;
	endfunction

	task automatic note_failure(string what, logic [15:0] want, logic [15:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
	endtask

	// Check each result transfer against the oldest expectation, then record a new transfer.
	always @(posedge clk) begin
		cbmm_pkg::rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_decode_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result with no access pending", $realtime);
				end else begin
					want = expected_decode_q.pop_front();
					if (result.target !== want.target)
						note_failure("target", want.target, result.target);
					if (result.target_address !== want.target_address)
						note_failure("target_address", want.target_address,
							result.target_address);
					if (result.forward_data !== want.forward_data)
						note_failure("forward_data", want.forward_data, result.forward_data);
					if (result.forward_write !== want.forward_write)
						note_failure("forward_write", want.forward_write, result.forward_write);
					if (result.read_data !== want.read_data)
						note_failure("read_data", want.read_data, result.read_data);
				end
			end
			if (start && !busy)
				expected_decode_q.push_back(decode_access(cmd));
		end
	end

	// Present one access and hold it until the block takes it.
	task automatic send_access(logic [1:0] kind, logic [15:0] addr, logic [7:0] data);
		start <= 1'b1;
		cmd <= '{func: kind, bus_address: addr, write_data: data};
		do @(posedge clk); while (busy);
	endtask

	// Stop sending and wait for every outstanding result.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (expected_decode_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_mirroring(logic vertical);
		cfg_we <= 1'b1;
		cfg_wdata <= vertical;
		@(posedge clk);
		cfg_we <= 1'b0;
		vertical_mirroring = vertical;
	endtask

	// Work RAM mirrors, register folding, the I/O page and the open range.
	task automatic test_cpu_map();
		send_access(cbmm_pkg::FUNC_CPU_WR, 16'h0000, 8'hFF);
		send_access(cbmm_pkg::FUNC_CPU_RD, 16'h1800, 8'h00);
		send_access(cbmm_pkg::FUNC_CPU_WR, 16'h1FFF, 8'h00);
		send_access(cbmm_pkg::FUNC_CPU_RD, 16'h07FF, 8'hFF);
		send_access(cbmm_pkg::FUNC_CPU_WR, 16'h2000, 8'h81);
		send_access(cbmm_pkg::FUNC_CPU_RD, 16'h3FFF, 8'h00);
		send_access(cbmm_pkg::FUNC_CPU_WR, 16'h4013, 8'h3C);
		send_access(cbmm_pkg::FUNC_CPU_WR, CPU_OAM_DMA, 8'h02);
		send_access(cbmm_pkg::FUNC_CPU_RD, CPU_APU_STATUS, 8'h00);
		send_access(cbmm_pkg::FUNC_CPU_WR, CPU_PAD1, 8'h01);
		send_access(cbmm_pkg::FUNC_CPU_RD, CPU_PAD2, 8'h00);
		send_access(cbmm_pkg::FUNC_CPU_WR, CPU_PAD2, 8'h40);
		send_access(cbmm_pkg::FUNC_CPU_WR, 16'h4018, 8'h55);
		send_access(cbmm_pkg::FUNC_CPU_RD, 16'h5FFF, 8'h00);
		send_access(cbmm_pkg::FUNC_CPU_WR, CPU_PRG_START, 8'h12);
		send_access(cbmm_pkg::FUNC_CPU_WR, 16'hFFFF, 8'hFF);
	endtask

	// Pattern space, nametable quadrants under the current mirroring, palette folding.
	task automatic test_ppu_map();
		send_access(cbmm_pkg::FUNC_PPU_WR, 16'h0000, 8'hFF);
		send_access(cbmm_pkg::FUNC_PPU_RD, 16'h1FFF, 8'h00);
		send_access(cbmm_pkg::FUNC_PPU_WR, 16'h2000, 8'h5A);
		send_access(cbmm_pkg::FUNC_PPU_RD, 16'h2400, 8'h00);
		send_access(cbmm_pkg::FUNC_PPU_RD, 16'h2800, 8'h00);
		send_access(cbmm_pkg::FUNC_PPU_WR, 16'h3EFF, 8'hFF);
		send_access(cbmm_pkg::FUNC_PPU_RD, 16'h2EFF, 8'h00);
		send_access(cbmm_pkg::FUNC_PPU_WR, 16'h3F20, 8'h0F);
		send_access(cbmm_pkg::FUNC_PPU_RD, 16'hFFFF, 8'h00);
	endtask

	// Mixed traffic, weighted toward the interesting regions and toward
	// small working sets so that reads see earlier writes through the mirrors.
	task automatic test_random_traffic(int count, int idle_pct);
		int          sel;
		logic [1:0]  kind;
		logic [15:0] addr;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 9);
			kind = $urandom_range(0, 1) ? cbmm_pkg::FUNC_CPU_WR : cbmm_pkg::FUNC_CPU_RD;
			addr = $urandom_range(0, 16'hFFFF);
			case (sel)
				0, 1, 2: begin
					kind = $urandom_range(0, 3);
				end
				3: begin
					addr = $urandom_range(0, CPU_WRAM_END);
				end
				4: begin
					addr = 16'h4000 + $urandom_range(0, 31);
				end
				5, 6: begin
					kind = $urandom_range(0, 1) ? cbmm_pkg::FUNC_PPU_WR : cbmm_pkg::FUNC_PPU_RD;
					addr = $urandom_range(16'h2000, 16'h3EFF);
					addr[15:14] = $urandom_range(0, 3);
				end
				7: begin
					kind = $urandom_range(0, 1) ? cbmm_pkg::FUNC_PPU_WR : cbmm_pkg::FUNC_PPU_RD;
					addr = $urandom_range(16'h3F00, 16'h3FFF);
					addr[15:14] = $urandom_range(0, 3);
				end
				8: begin
					addr = $urandom_range(0, 1) ? $urandom_range(16'h2000, 16'h3FFF)
						: $urandom_range(CPU_PRG_START, 16'hFFFF);
				end
				default: begin
					if ($urandom_range(0, 1)) begin
						kind = $urandom_range(0, 1) ? cbmm_pkg::FUNC_PPU_WR
							: cbmm_pkg::FUNC_PPU_RD;
						addr = 16'h2000 | ($urandom_range(0, 3) << 10) | $urandom_range(0, 7);
					end else begin
						addr = ($urandom_range(0, 3) << 11) | $urandom_range(0, 7);
					end
				end
			endcase
			if ($urandom_range(0, 99) < idle_pct) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			send_access(kind, addr, $urandom_range(0, 255));
			// Now and then let the pipeline run dry before going on.
			if ($urandom_range(0, 49) == 0)
				drain_results();
		end
	endtask

	// Test sequence.
	initial begin
		for (int i = 0; i < 2048; i++) begin
			wram_image[i] = 8'h00;
			ntram_image[i] = 8'h00;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// The register is taken during the clearing pass as well.
		set_mirroring(1'b1);
		test_cpu_map();
		test_ppu_map();
		drain_results();
		set_mirroring(1'b0);
		test_random_traffic(125, 0);
		drain_results();
		set_mirroring(1'b1);
		test_random_traffic(125, 69);
		drain_results();
		set_mirroring(1'b0);
		test_random_traffic(125, 0);
		drain_results();
		set_mirroring(1'b1);
		test_random_traffic(125, 37);
		drain_results();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && expected_decode_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
